// File: hdl/ppdbt_pkg.sv
// Shared types and constants for the ping-pong DMA block tracker.
// No dependencies; front, back and top use scoped names; tb imports it.
package ppdbt_pkg;

  localparam int SIZE_W     = 17;   // block_size register
  localparam int CNT_W      = 11;   // block_count register
  localparam int ADDR_W     = 20;   // byte offsets and read position
  localparam int PEND_W     = 21;   // pending byte count
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int Q_DEPTH    = 2;

  localparam int MAX_BLOCKS_DEF       = 1024;
  localparam int MAX_BUFFER_BYTES_DEF = 1048576;

  localparam logic [SIZE_W-1:0] SIZE_MIN  = 17'd256;
  localparam logic [SIZE_W-1:0] SIZE_MAX  = 17'd65536;
  localparam logic [SIZE_W-1:0] SIZE_RST  = 17'd4096;
  localparam logic [CNT_W-1:0]  COUNT_RST = 11'd4;
  localparam int                COUNT_MIN = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE  = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_OPEN  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_DONE  = 3'd3,
    ACT_QUERY = 3'd4
  } action_t;

  // decoded command passed from front to back
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_OPEN,
    CMD_START,
    CMD_STOP,
    CMD_DONE,
    CMD_QUERY
  } cmd_t;

  typedef enum logic [2:0] {
    F_START,
    F_LIM,
    F_RING,
    F_THR,
    F_MOD,
    F_RUN
  } front_state_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             even_field;
  } in_word_t;

  typedef struct packed {
    cmd_t cmd;
    logic even_field;
  } cmd_word_t;

  typedef struct packed {
    logic              address_valid;
    logic              base_select;
    logic [ADDR_W-1:0] next_address;
    logic              overrun;
    logic              period_elapsed;
    logic              field_mismatch;
    logic [ADDR_W-1:0] position_bytes;
  } out_word_t;

endpackage

// File: hdl/ppdbt_fifo.sv
// Small register queue, first in first out, with full/empty flags.
// Depends on nothing; word width and depth come from parameters.
module ppdbt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: hdl/ppdbt_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the front end for ring limits and block wrap.
module ppdbt_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int KW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [KW-1:0]    cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, quot_r[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});
  assign diff   = rem_sh - {1'b0, den_r};

  assign busy = busy_r;
  assign quot = quot_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == KW'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      rem_r  <= '0;
      den_r  <= den;
      cnt_r  <= KW'(NUM_W);
    end else if (busy_r) begin
      quot_r <= {quot_r[NUM_W-2:0], ge};
      rem_r  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_r  <= cnt_r - 1'b1;
    end
  end

endmodule

// File: hdl/ppdbt_front.sv
// Front end: configuration registers, derived ring limits, word decode.
// Depends on ppdbt_pkg and ppdbt_div.
module ppdbt_front #(
  parameter int MAX_BLOCKS       = ppdbt_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_BUFFER_BYTES = ppdbt_pkg::MAX_BUFFER_BYTES_DEF,
  localparam int BW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CW = $clog2(MAX_BLOCKS + 1),
  localparam int RW = ppdbt_pkg::SIZE_W + CW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ppdbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppdbt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_push,
  input  ppdbt_pkg::in_word_t                 in_word,
  output logic                                in_full,
  output logic                                cmd_push,
  output ppdbt_pkg::cmd_word_t                cmd_word,
  input  logic                                cmd_full,
  input  logic [BW-1:0]                       cur_block,
  output logic [ppdbt_pkg::SIZE_W-1:0]        eff_size,
  output logic [CW-1:0]                       eff_count,
  output logic [RW-1:0]                       ring,
  output logic [RW-1:0]                       thresh,
  output logic                                fix_valid,
  output logic [BW-1:0]                       fix_block
);

  localparam int NW = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int SW = ppdbt_pkg::SIZE_W;

  ppdbt_pkg::front_state_t state_r, state_nxt;

  logic [SW-1:0]                 size_r;
  logic [ppdbt_pkg::CNT_W-1:0]   count_r;
  logic [SW-1:0]                 size_sat;
  logic [SW-1:0]                 eff_size_r;
  logic [CW-1:0]                 eff_count_r, eff_count_nxt;
  logic [RW-1:0]                 ring_r;
  logic [RW-1:0]                 thresh_r;
  logic [NW-1:0]                 cnt_clip;

  logic          div_start;
  logic [NW-1:0] div_num;
  logic [SW-1:0] div_den;
  logic          div_busy;
  logic [NW-1:0] div_quot;
  logic [SW-1:0] div_rem;

  ppdbt_div #(.NUM_W(NW), .DEN_W(SW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= ppdbt_pkg::SIZE_RST;
      count_r <= ppdbt_pkg::COUNT_RST;
    end else if (cfg_wr_en) begin
      case (ppdbt_pkg::reg_idx_t'(cfg_index))
        ppdbt_pkg::REG_BLOCK_SIZE:  size_r  <= cfg_data[SW-1:0];
        ppdbt_pkg::REG_BLOCK_COUNT: count_r <= cfg_data[ppdbt_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    size_sat = size_r;
    if (size_r < ppdbt_pkg::SIZE_MIN) size_sat = ppdbt_pkg::SIZE_MIN;
    if (size_r > ppdbt_pkg::SIZE_MAX) size_sat = ppdbt_pkg::SIZE_MAX;
  end

  // count clipped to MAX_BLOCKS, then to the ring limit, floor of two
  always_comb begin
    cnt_clip = NW'(count_r);
    if (cnt_clip > NW'(MAX_BLOCKS)) cnt_clip = NW'(MAX_BLOCKS);
    if (cnt_clip > div_quot)        cnt_clip = div_quot;
    if (cnt_clip < NW'(ppdbt_pkg::COUNT_MIN)) cnt_clip = NW'(ppdbt_pkg::COUNT_MIN);
    eff_count_nxt = CW'(cnt_clip);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppdbt_pkg::F_START: state_nxt = ppdbt_pkg::F_LIM;
      ppdbt_pkg::F_LIM:   if (!div_busy) state_nxt = ppdbt_pkg::F_RING;
      ppdbt_pkg::F_RING:  state_nxt = ppdbt_pkg::F_THR;
      ppdbt_pkg::F_THR:   state_nxt = ppdbt_pkg::F_MOD;
      ppdbt_pkg::F_MOD:   if (!div_busy) state_nxt = ppdbt_pkg::F_RUN;
      ppdbt_pkg::F_RUN:   state_nxt = ppdbt_pkg::F_RUN;
      default:            state_nxt = ppdbt_pkg::F_START;
    endcase
    if (cfg_wr_en) state_nxt = ppdbt_pkg::F_START;
  end

  // outputs of the sequencer
  always_comb begin
    div_start = 1'b0;
    div_num   = NW'(MAX_BUFFER_BYTES);
    div_den   = size_sat;
    fix_valid = 1'b0;
    unique case (state_r)
      ppdbt_pkg::F_START: div_start = 1'b1;
      ppdbt_pkg::F_THR: begin
        div_start = 1'b1;
        div_num   = NW'(cur_block);
        div_den   = SW'(eff_count_r);
      end
      ppdbt_pkg::F_MOD: fix_valid = !div_busy;
      default: ;
    endcase
  end

  assign fix_block = BW'(div_rem);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppdbt_pkg::F_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ppdbt_pkg::F_START) eff_size_r <= size_sat;
    if (state_r == ppdbt_pkg::F_LIM && !div_busy) eff_count_r <= eff_count_nxt;
    if (state_r == ppdbt_pkg::F_RING) ring_r <= RW'(eff_size_r) * RW'(eff_count_r);
    if (state_r == ppdbt_pkg::F_THR) thresh_r <= ring_r - (RW'(eff_size_r) << 1);
  end

  assign eff_size  = eff_size_r;
  assign eff_count = eff_count_r;
  assign ring      = ring_r;
  assign thresh    = thresh_r;

  // word decode
  assign in_full  = (state_r != ppdbt_pkg::F_RUN) || cmd_full;
  assign cmd_push = in_push && !in_full;

  always_comb begin
    cmd_word.even_field = in_word.even_field;
    unique case (ppdbt_pkg::action_t'(in_word.action))
      ppdbt_pkg::ACT_OPEN:  cmd_word.cmd = ppdbt_pkg::CMD_OPEN;
      ppdbt_pkg::ACT_START: cmd_word.cmd = ppdbt_pkg::CMD_START;
      ppdbt_pkg::ACT_STOP:  cmd_word.cmd = ppdbt_pkg::CMD_STOP;
      ppdbt_pkg::ACT_DONE:  cmd_word.cmd = ppdbt_pkg::CMD_DONE;
      ppdbt_pkg::ACT_QUERY: cmd_word.cmd = ppdbt_pkg::CMD_QUERY;
      default:              cmd_word.cmd = ppdbt_pkg::CMD_NOP;
    endcase
  end

endmodule

// File: hdl/ppdbt_back.sv
// Back end: tracker state update, then address multiply into the result queue.
// Depends on ppdbt_pkg.
module ppdbt_back #(
  parameter int MAX_BLOCKS = ppdbt_pkg::MAX_BLOCKS_DEF,
  localparam int BW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CW = $clog2(MAX_BLOCKS + 1),
  localparam int RW = ppdbt_pkg::SIZE_W + CW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  ppdbt_pkg::cmd_word_t          cmd_word,
  output logic                          cmd_pop,
  input  logic [ppdbt_pkg::SIZE_W-1:0]  eff_size,
  input  logic [CW-1:0]                 eff_count,
  input  logic [RW-1:0]                 ring,
  input  logic [RW-1:0]                 thresh,
  input  logic                          fix_valid,
  input  logic [BW-1:0]                 fix_block,
  output logic [BW-1:0]                 cur_block,
  output logic                          res_push,
  output ppdbt_pkg::out_word_t          res_word,
  input  logic                          res_full
);

  localparam int AW = ppdbt_pkg::ADDR_W;
  localparam int PW = ppdbt_pkg::PEND_W;
  localparam int SW = ppdbt_pkg::SIZE_W;
  localparam int XW = (RW > PW) ? RW : PW;
  localparam int MW = (BW + SW > AW) ? BW + SW : AW;

  // blk_r is the block index reduced into the current ring; raw_blk_r is the
  // index as last set, kept so a later ring change reduces from it again
  logic          running_r, running_nxt;
  logic [BW-1:0] blk_r, blk_nxt;
  logic [BW-1:0] raw_blk_r, raw_blk_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic [AW-1:0] rpos_r, rpos_nxt;

  logic                 s2_valid_r;
  ppdbt_pkg::out_word_t s2_word_r, s2_word_nxt;
  logic [BW-1:0]        s2_blk_r, s2_blk_nxt;

  logic          s1_go;
  logic          s2_take;
  logic [CW:0]   sum1, sum2, wrap2;
  logic [PW:0]   padd;
  logic [AW:0]   pos;
  logic          match;
  logic [MW-1:0] prod;

  assign s2_take = s2_valid_r && !res_full;
  assign s1_go   = cmd_valid && (!s2_valid_r || !res_full);
  assign cmd_pop = s1_go;

  assign sum1  = (CW+1)'(blk_r) + (CW+1)'(1);
  assign sum2  = (CW+1)'(blk_r) + (CW+1)'(2);
  assign wrap2 = (sum2 >= (CW+1)'(eff_count)) ? sum2 - (CW+1)'(eff_count) : sum2;
  assign padd  = (PW+1)'(pend_r) + (PW+1)'(eff_size);
  assign pos   = (AW+1)'(rpos_r) + (AW+1)'(eff_size);
  assign match = cmd_word.even_field ? blk_r[0] : !blk_r[0];

  always_comb begin
    running_nxt = running_r;
    blk_nxt     = blk_r;
    raw_blk_nxt = raw_blk_r;
    pend_nxt    = pend_r;
    rpos_nxt    = rpos_r;
    s2_word_nxt = '0;
    s2_blk_nxt  = '0;
    case (cmd_word.cmd)
      ppdbt_pkg::CMD_OPEN: begin
        pend_nxt = '0;
        rpos_nxt = '0;
      end
      ppdbt_pkg::CMD_START: begin
        running_nxt = 1'b1;
        blk_nxt     = '0;
        raw_blk_nxt = '0;
      end
      ppdbt_pkg::CMD_STOP: begin
        running_nxt = 1'b0;
        blk_nxt     = '0;
        raw_blk_nxt = '0;
      end
      ppdbt_pkg::CMD_DONE: begin
        if (running_r) begin
          if (!match) begin
            s2_word_nxt.field_mismatch = 1'b1;
          end else if (XW'(pend_r) >= XW'(thresh)) begin
            s2_word_nxt.overrun = 1'b1;
            running_nxt         = 1'b0;
            blk_nxt             = '0;
            raw_blk_nxt         = '0;
          end else begin
            s2_word_nxt.address_valid = 1'b1;
            s2_word_nxt.base_select   = cmd_word.even_field;
            s2_blk_nxt                = BW'(wrap2);
            blk_nxt     = (sum1 == (CW+1)'(eff_count)) ? '0 : BW'(sum1);
            raw_blk_nxt = blk_nxt;
            pend_nxt = padd[PW] ? '1 : padd[PW-1:0];
            s2_word_nxt.period_elapsed = (pend_nxt >= PW'(eff_size));
          end
        end
      end
      ppdbt_pkg::CMD_QUERY: begin
        if (pend_r != '0) begin
          pend_nxt = (pend_r > PW'(eff_size)) ? pend_r - PW'(eff_size) : '0;
          rpos_nxt = (XW'(pos) >= XW'(ring)) ? '0 : pos[AW-1:0];
        end
        s2_word_nxt.position_bytes = rpos_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= 1'b0;
      blk_r      <= '0;
      raw_blk_r  <= '0;
      pend_r     <= '0;
      rpos_r     <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      if (fix_valid) begin
        blk_r <= fix_block;
      end else if (s1_go) begin
        running_r <= running_nxt;
        blk_r     <= blk_nxt;
        raw_blk_r <= raw_blk_nxt;
        pend_r    <= pend_nxt;
        rpos_r    <= rpos_nxt;
      end
      if (s1_go) begin
        s2_valid_r <= 1'b1;
      end else if (s2_take) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_word_r <= s2_word_nxt;
      s2_blk_r  <= s2_blk_nxt;
    end
  end

  // block-two-ahead offset, masked to the address width
  assign prod = MW'(s2_blk_r) * MW'(eff_size);

  always_comb begin
    res_word              = s2_word_r;
    res_word.next_address = s2_word_r.address_valid ? prod[AW-1:0] : '0;
  end

  assign res_push  = s2_take;
  assign cur_block = raw_blk_r;

endmodule

// File: hdl/ping_pong_dma_block_tracker.sv
// Top level of the ping-pong DMA block tracker.
// Depends on ppdbt_pkg, ppdbt_front, ppdbt_back and ppdbt_fifo.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+--------------------------------
//  input   | in_push, in_full, in_word      | word taken when push && !full
//  result  | out_pop, out_empty, out_word   | word taken when pop && !empty
//  config  | cfg_wr_en, cfg_index, cfg_data | written on any edge with wr_en
//
// One word per cycle sustained while full is low; a result can be popped once
// its input word has passed the decode queue, the state update and multiply
// stage and the result queue. After reset and after every config write, full
// stays high while the ring limits are rebuilt: a divide for the count limit,
// the ring product, the threshold, then a second divide for the block wrap.
// Reset is synchronous, active low; a stalled result side backs up through
// the output queue and the decode queue into full.
module ping_pong_dma_block_tracker #(
  parameter int MAX_BLOCKS       = ppdbt_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_BUFFER_BYTES = ppdbt_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  ppdbt_pkg::in_word_t              in_word,
  output logic                             out_empty,
  input  logic                             out_pop,
  output ppdbt_pkg::out_word_t             out_word,
  input  logic                             cfg_wr_en,
  input  logic [ppdbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppdbt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int BW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int RW = ppdbt_pkg::SIZE_W + CW;
  localparam int CMD_WW = $bits(ppdbt_pkg::cmd_word_t);
  localparam int OUT_WW = $bits(ppdbt_pkg::out_word_t);

  // front -> decode queue
  logic                 cmd_push;
  ppdbt_pkg::cmd_word_t cmd_word_in;
  logic                 cmd_full;

  // decode queue -> back
  logic                 cmd_empty;
  logic                 cmd_pop;
  logic [CMD_WW-1:0]    cmd_dout;

  // derived configuration and block fix-up
  logic [ppdbt_pkg::SIZE_W-1:0] eff_size;
  logic [CW-1:0]                eff_count;
  logic [RW-1:0]                ring;
  logic [RW-1:0]                thresh;
  logic                         fix_valid;
  logic [BW-1:0]                fix_block;
  logic [BW-1:0]                cur_block;

  // back -> result queue
  logic                 res_push;
  ppdbt_pkg::out_word_t res_word;
  logic                 res_full;
  logic [OUT_WW-1:0]    res_dout;

  ppdbt_front #(
    .MAX_BLOCKS       (MAX_BLOCKS),
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .cmd_push  (cmd_push),
    .cmd_word  (cmd_word_in),
    .cmd_full  (cmd_full),
    .cur_block (cur_block),
    .eff_size  (eff_size),
    .eff_count (eff_count),
    .ring      (ring),
    .thresh    (thresh),
    .fix_valid (fix_valid),
    .fix_block (fix_block)
  );

  // decoded words wait here so the front keeps taking input while the back stalls
  ppdbt_fifo #(
    .WIDTH (CMD_WW),
    .DEPTH (ppdbt_pkg::Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_word_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  ppdbt_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd_word  (ppdbt_pkg::cmd_word_t'(cmd_dout)),
    .cmd_pop   (cmd_pop),
    .eff_size  (eff_size),
    .eff_count (eff_count),
    .ring      (ring),
    .thresh    (thresh),
    .fix_valid (fix_valid),
    .fix_block (fix_block),
    .cur_block (cur_block),
    .res_push  (res_push),
    .res_word  (res_word),
    .res_full  (res_full)
  );

  // result queue: the oldest result sits on out_word while not empty
  ppdbt_fifo #(
    .WIDTH (OUT_WW),
    .DEPTH (ppdbt_pkg::Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_word),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_dout),
    .empty (out_empty)
  );

  assign out_word = ppdbt_pkg::out_word_t'(res_dout);

endmodule

// File: sim/ping_pong_dma_block_tracker_tb.sv
`timescale 1ns / 100ps
// Testbench for ping_pong_dma_block_tracker: random and directed events against a
// scoreboard that tracks the ring state. Depends on ppdbt_pkg and the block's RTL.
module ping_pong_dma_block_tracker_tb;
  import ppdbt_pkg::*;

  // Cycles with no word moving on either side before the run is declared hung.
  // Worst legit quiet stretch is the ring-limit rebuild after a config write
  // or a bursty receiver stall, and this limit is many times over either.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_TAIL     = 16;     // extra margin after the last result
  localparam int PHASES         = 9;
  localparam int PHASE_WORDS    = 136;
  localparam longint unsigned PEND_FULL = (64'd1 << PEND_W) - 1;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;

  // Scoreboard: keeps its own copy of the ring registers and tracker state,
  // computes the result word for every accepted event and checks results in order.
  class ring_scoreboard;
    out_word_t        owed_words[$];
    bit [SIZE_W-1:0]  size_reg;
    bit [CNT_W-1:0]   count_reg;
    bit [9:0]         blk_now;
    bit               running;
    bit [PEND_W-1:0]  pend_bytes;
    bit [ADDR_W-1:0]  read_pos;
    int               errors, checked, overruns, rejects, wraps;

    function new();
      size_reg   = SIZE_RST;
      count_reg  = COUNT_RST;
      blk_now    = '0;
      running    = 1'b0;
      pend_bytes = '0;
      read_pos   = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_BLOCK_SIZE) size_reg = val[SIZE_W-1:0];
      else count_reg = val[CNT_W-1:0];
    endfunction

    // Effective block size and count after saturation and the ring-size cap.
    function void ring_dims(output int unsigned sz, output int unsigned cnt);
      int unsigned lim;
      sz = size_reg;
      if (sz < SIZE_MIN) sz = SIZE_MIN;
      if (sz > SIZE_MAX) sz = SIZE_MAX;
      lim = MAX_BUFFER_BYTES_DEF / sz;
      cnt = count_reg;
      if (cnt > MAX_BLOCKS_DEF) cnt = MAX_BLOCKS_DEF;
      if (cnt > lim) cnt = lim;
      if (cnt < COUNT_MIN) cnt = COUNT_MIN;
    endfunction

    // Parity a block-done needs right now to be accepted.
    function bit done_parity();
      int unsigned sz, cnt;
      ring_dims(sz, cnt);
      return 1'((blk_now % cnt) & 1);
    endfunction

    function void note_word(in_word_t w);
      out_word_t         r;
      int unsigned       sz, cnt, blk, nxt;
      longint unsigned   ring, sum;
      r = '0;
      ring_dims(sz, cnt);
      ring = longint'(sz) * cnt;
      case (w.action)
        ACT_OPEN: begin
          pend_bytes = '0;
          read_pos   = '0;
        end
        ACT_START: begin
          blk_now = '0;
          running = 1'b1;
        end
        ACT_STOP: begin
          blk_now = '0;
          running = 1'b0;
        end
        ACT_DONE: begin
          // done while stopped gives an all-zero word
          if (running) begin
            // block index may sit past a ring that shrank under it
            blk = blk_now % cnt;
            if (w.even_field != blk[0]) begin
              r.field_mismatch = 1'b1;
              rejects++;
            end else if (pend_bytes >= sz * (cnt - 2)) begin
              r.overrun = 1'b1;
              running   = 1'b0;
              blk_now   = '0;
              overruns++;
            end else begin
              nxt = (blk + 2) % cnt;
              r.address_valid = 1'b1;
              r.base_select   = w.even_field;
              r.next_address  = ADDR_W'(nxt * sz);
              blk_now = 10'((blk + 1) % cnt);
              sum = pend_bytes + sz;
              pend_bytes = PEND_W'((sum > PEND_FULL) ? PEND_FULL : sum);
              r.period_elapsed = (pend_bytes >= sz);
            end
          end
        end
        ACT_QUERY: begin
          if (pend_bytes != 0) begin
            // underflow saturates at zero
            pend_bytes = (pend_bytes > sz) ? PEND_W'(pend_bytes - sz) : '0;
            sum = read_pos + sz;
            if (sum >= ring) begin
              sum = 0;
              wraps++;
            end
            read_pos = ADDR_W'(sum);
          end
          r.position_bytes = read_pos;
        end
        default: ;  // undefined actions leave everything alone
      endcase
      owed_words.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (owed_words.size() == 0) begin
        $display("%0t: result word with none expected, got %p", $time, got);
        errors++;
        return;
      end
      want = owed_words.pop_front();
      checked++;
      cmp_field("address_valid", want.address_valid, got.address_valid);
      cmp_field("base_select", want.base_select, got.base_select);
      cmp_field("next_address", want.next_address, got.next_address);
      cmp_field("overrun", want.overrun, got.overrun);
      cmp_field("period_elapsed", want.period_elapsed, got.period_elapsed);
      cmp_field("field_mismatch", want.field_mismatch, got.field_mismatch);
      cmp_field("position_bytes", want.position_bytes, got.position_bytes);
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_push   = 1'b0;
  logic                  in_full;
  in_word_t              in_word   = '0;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  out_word_t             out_word;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  ring_scoreboard sb = new();
  int unsigned    words_sent  = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    rx_tick     = 0;
  rx_mode_t       rx_mode     = RX_FLOW;

  ping_pong_dma_block_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Present one word and hold it until the block takes it. push is left high
  // so a following word goes out back to back; callers lower it for gaps.
  task automatic send_word(input logic [ACT_W-1:0] act, input logic ev);
    in_word_t w;
    w.action     = act;
    w.even_field = ev;
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full !== 1'b0);
    sb.note_word(w);
    words_sent++;
  endtask

  // Mostly well-formed capture traffic: start when stopped, block-done with the
  // parity the current block wants, queries to drain. The rest is noise:
  // wrong parity, stray start/stop/open and undefined actions.
  task automatic send_random();
    int unsigned      roll;
    logic [ACT_W-1:0] act;
    logic             ev;
    roll = $urandom_range(0, 99);
    ev   = 1'($urandom_range(0, 1));
    if (!sb.running && $urandom_range(0, 2) != 0) act = ACT_START;
    else if (roll < 50) begin
      act = ACT_DONE;
      ev  = sb.done_parity();
    end
    else if (roll < 58) act = ACT_DONE;
    else if (roll < 82) act = ACT_QUERY;
    else if (roll < 86) act = ACT_START;
    else if (roll < 89) act = ACT_STOP;
    else if (roll < 93) act = ACT_OPEN;
    else if (roll < 96) act = ACT_W'($urandom_range(ACT_QUERY + 1, 2**ACT_W - 1));
    else act = ACT_W'($urandom_range(0, 2**ACT_W - 1));
    send_word(act, ev);
  endtask

  // Bursts of random length with random gaps; some phases run gap-free.
  task automatic run_phase(input int n);
    int sent;
    int burst;
    int gap;
    bit steady;
    sent   = 0;
    steady = ($urandom_range(0, 3) == 0);
    while (sent < n) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < n; k++) begin
        send_random();
        sent++;
      end
      gap = (steady || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
      // push only drops when there is a real gap, never lowered and raised in one step
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending and wait for every owed result, then an optional tail.
  task automatic drain(input int tail);
    in_push <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Both registers written on consecutive edges with the enable held high.
  task automatic set_ring(input logic [CFG_DATA_W-1:0] size_val, count_val);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_BLOCK_SIZE;
    cfg_data  <= size_val;
    @(posedge clk);
    sb.write_reg(REG_BLOCK_SIZE, size_val);
    cfg_index <= REG_BLOCK_COUNT;
    cfg_data  <= count_val;
    @(posedge clk);
    sb.write_reg(REG_BLOCK_COUNT, count_val);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: pops on a randomly re-chosen mode - always ready, mostly ready,
  // mostly stalled, or bursty: stalled for most of each period, then ready.
  always @(posedge clk) begin
    if (rst_n && out_pop && out_empty === 1'b0) sb.check_word(out_word);
    rx_tick++;
    if (rx_tick % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FLOW:  out_pop <= 1'b1;
      RX_LIGHT: out_pop <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_pop <= ($urandom_range(0, 3) == 0);
      default:  out_pop <= ((rx_tick % 32) >= 24);
    endcase
  end

  // Watchdog: counts cycles where neither side moves a word.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && in_full === 1'b0) || (out_pop && out_empty === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** ping_pong_dma_block_tracker: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] size_plan [PHASES];
    logic [CFG_DATA_W-1:0] count_plan[PHASES];
    // Ring settings per phase: saturation limits, raw register extremes,
    // the byte cap on the count, an odd count, a full 1 MiB ring, and two
    // random ones. State is not cleared between phases, so the block index
    // can land past a ring that just shrank.
    size_plan  = '{17'd256, 17'd65536, 17'd0, 17'h1FFFF, 17'd4096,
                   17'd1000, 17'd1024, 17'd0, 17'd0};
    count_plan = '{17'd2, 17'd16, 17'd0, 17'h1F802, 17'd256,
                   17'd7, 17'd1024, 17'd0, 17'd0};
    size_plan[PHASES-2]  = CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1));
    count_plan[PHASES-2] = CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1));
    size_plan[PHASES-1]  = CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1));
    count_plan[PHASES-1] = CFG_DATA_W'($urandom_range(2, 40));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass at reset settings (4 blocks of 4096): query with nothing
    // pending, done while stopped, undefined actions, wrong parity, two good
    // blocks then overrun, draining queries, restart and stop.
    send_word(ACT_OPEN, 1'b1);
    send_word(ACT_QUERY, 1'b0);
    send_word(ACT_DONE, 1'b0);
    for (int a = ACT_QUERY + 1; a < 2**ACT_W; a++) send_word(ACT_W'(a), a[0]);
    send_word(ACT_START, 1'b1);
    send_word(ACT_DONE, 1'b1);
    send_word(ACT_DONE, 1'b0);
    send_word(ACT_DONE, 1'b1);
    send_word(ACT_DONE, 1'b0);
    send_word(ACT_DONE, 1'b1);
    send_word(ACT_QUERY, 1'b1);
    send_word(ACT_QUERY, 1'b0);
    send_word(ACT_QUERY, 1'b1);
    send_word(ACT_START, 1'b0);
    send_word(ACT_DONE, 1'b0);
    send_word(ACT_DONE, 1'b1);
    send_word(ACT_QUERY, 1'b0);
    send_word(ACT_DONE, 1'b0);
    send_word(ACT_STOP, 1'b0);
    send_word(ACT_DONE, 1'b1);
    send_word(ACT_OPEN, 1'b0);
    send_word(ACT_STOP, 1'b1);
    send_word(ACT_QUERY, 1'b1);

    // Each phase: wait until everything owed has come out, reprogram, run.
    for (int p = 0; p < PHASES; p++) begin
      drain(0);
      set_ring(size_plan[p], count_plan[p]);
      run_phase(PHASE_WORDS);
    end
    drain(DRAIN_TAIL);

    $display("Run sent %0d words over %0d ring settings plus reset; %0d results checked.",
             words_sent, PHASES, sb.checked);
    $display("Saw %0d overruns, %0d parity rejects, %0d position wraps; %0d errors.",
             sb.overruns, sb.rejects, sb.wraps, sb.errors);
    if (sb.errors == 0)
      $display("** ping_pong_dma_block_tracker: PASSED **");
    else
      $display("** ping_pong_dma_block_tracker: FAILED **");
    $finish;
  end

endmodule
